FILE: src/ctu_pkg.sv
// Shared types and constants for the ciphertext unpacker.
`default_nettype none

package ctu_pkg;

    localparam int POLY_COUNT_DEFAULT = 3;
    localparam int C1_POLY_BYTES      = 320;
    localparam int C2_BYTES           = 128;
    localparam int WORK_DEPTH         = 4;
    localparam int RESULT_DEPTH       = 2;

    localparam logic [11:0] Q_MOD         = 12'd3329;
    localparam logic [1:0]  V_POLY_SELECT = 2'd3;
    localparam logic [4:0]  VALUE_BITS    = 5'd10;

    typedef enum logic
    {
        KIND_C1 = 1'b0,
        KIND_C2 = 1'b1
    } kind_t;

    // One unit of work handed from the front to the back.
    typedef struct packed
    {
        kind_t       kind;
        logic [9:0]  value;   // 10-bit value, or the c2 byte in bits 7:0
        logic [9:0]  count;   // coefficient counter for the first result
        logic        last;    // byte closes the ciphertext
    } work_t;

    typedef struct packed
    {
        logic [11:0] coefficient;
        logic [1:0]  poly_select;
        logic [7:0]  coeff_index;
        logic        run_last;
        logic        cipher_last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/ctu_fifo.sv
// Small first-in first-out queue with registered storage.
`default_nettype none

module ctu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: src/ctu_front.sv
// Byte intake: position tracking, 10-bit gearbox and work classification.
`default_nettype none

module ctu_front #(
    parameter int POLY_COUNT = ctu_pkg::POLY_COUNT_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] cipher_byte,
    output logic            work_valid,
    output ctu_pkg::work_t  work
);

    localparam int C1_BYTES    = POLY_COUNT * ctu_pkg::C1_POLY_BYTES;
    localparam int TOTAL_BYTES = C1_BYTES + ctu_pkg::C2_BYTES;

    logic [10:0] pos_reg;
    logic [10:0] pos_next;
    logic [16:0] buf_reg;
    logic [16:0] buf_next;
    logic [4:0]  fill_reg;
    logic [4:0]  fill_next;
    logic [9:0]  count_reg;
    logic [9:0]  count_next;

    logic        in_c1;
    logic        last_byte;
    logic [16:0] buf_merged;
    logic [4:0]  fill_added;
    logic        have_value;

    assign in_c1      = (pos_reg < 11'(C1_BYTES));
    assign last_byte  = (pos_reg == 11'(TOTAL_BYTES - 1));
    assign buf_merged = buf_reg | (17'(cipher_byte) << fill_reg[3:0]);
    assign fill_added = fill_reg + 5'd8;
    assign have_value = (fill_added >= ctu_pkg::VALUE_BITS);

    always_comb
    begin
        pos_next   = pos_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        work_valid = 1'b0;
        work.kind  = ctu_pkg::KIND_C1;
        work.value = buf_merged[9:0];
        work.count = count_reg;
        work.last  = last_byte;
        if (take)
        begin
            pos_next = pos_reg + 1'b1;
            if (in_c1)
            begin
                buf_next  = buf_merged;
                fill_next = fill_added;
                if (have_value)
                begin
                    // peel off one 10-bit value
                    buf_next   = buf_merged >> 10;
                    fill_next  = fill_added - ctu_pkg::VALUE_BITS;
                    count_next = count_reg + 1'b1;
                    work_valid = 1'b1;
                end
            end
            else
            begin
                work.kind  = ctu_pkg::KIND_C2;
                work.value = {2'b00, cipher_byte};
                count_next = count_reg + 10'd2;
                work_valid = 1'b1;
            end
            if (last_byte)
            begin
                pos_next   = '0;
                buf_next   = '0;
                fill_next  = '0;
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            buf_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ctu_back.sv
// Decompress: one coefficient per cycle, stalls on either queue.
`default_nettype none

module ctu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ctu_pkg::work_t  work,
    input  wire logic            work_empty,
    output logic                 work_pop,
    input  wire logic            result_full,
    output logic                 result_push,
    output ctu_pkg::result_t     result
);

    logic        phase_reg;
    logic        phase_next;
    logic        is_c2;
    logic        fire;
    logic [9:0]  x;
    logic [21:0] product;
    logic [21:0] rounded;
    logic [9:0]  idx_count;

    assign is_c2 = (work.kind == ctu_pkg::KIND_C2);
    assign fire  = !work_empty && !result_full;

    always_comb
    begin
        if (!is_c2)
        begin
            x = work.value;
        end
        else if (phase_reg)
        begin
            x = {6'd0, work.value[7:4]};
        end
        else
        begin
            x = {6'd0, work.value[3:0]};
        end
    end

    // one multiplier shared by both value widths
    assign product   = 22'(x) * 22'(ctu_pkg::Q_MOD);
    assign rounded   = is_c2 ? product + 22'd8 : product + 22'd512;
    assign idx_count = work.count + 10'(phase_reg);

    always_comb
    begin
        result_push = fire;
        work_pop    = fire && (!is_c2 || phase_reg);
        phase_next  = phase_reg;
        if (fire && is_c2)
        begin
            phase_next = !phase_reg;
        end
        if (is_c2)
        begin
            result.coefficient = rounded[15:4];
            result.poly_select = ctu_pkg::V_POLY_SELECT;
            result.run_last    = phase_reg;
            result.cipher_last = phase_reg && work.last;
        end
        else
        begin
            result.coefficient = rounded[21:10];
            result.poly_select = work.count[9:8];
            result.run_last    = 1'b1;
            result.cipher_last = 1'b0;
        end
        result.coeff_index = idx_count[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/mlkem_ciphertext_unpack.sv
// ML-KEM ciphertext unpacker top level: byte decode and decompress.
//
// Feed the ciphertext one byte per beat: POLY_COUNT*320 bytes of 10-bit u coefficients,
// then 128 bytes of 4-bit v coefficients; counters return to zero after the last byte.
// Bytes are taken at one per cycle while the four-entry work queue has room. The u part
// yields at most one coefficient per byte (one per cycle); each v byte yields two, and
// the single decompress multiplier writes one coefficient per cycle into the result
// queue while it has room, so a v byte stays at the work queue head until both of its
// coefficients are written. A coefficient passes through the work queue, the decompress
// stage and the result queue before it is visible on the result ports. run_last marks the
// final coefficient of a byte and cipher_last the final coefficient of the ciphertext.
`default_nettype none

module mlkem_ciphertext_unpack #(
    parameter int POLY_COUNT = ctu_pkg::POLY_COUNT_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] cipher_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [11:0]     coefficient,
    output logic [1:0]      poly_select,
    output logic [7:0]      coeff_index,
    output logic            run_last,
    output logic            cipher_last
);

    localparam int WORK_W   = $bits(ctu_pkg::work_t);
    localparam int RESULT_W = $bits(ctu_pkg::result_t);

    logic             take;
    logic             work_valid;
    ctu_pkg::work_t   work_in;
    ctu_pkg::work_t   work_head;
    logic [WORK_W-1:0] work_head_bits;
    logic             work_empty;
    logic             work_pop;
    logic             result_full;
    logic             result_push;
    ctu_pkg::result_t result_in;
    ctu_pkg::result_t result_head;
    logic [RESULT_W-1:0] result_head_bits;

    assign take        = push && !full;
    assign work_head   = ctu_pkg::work_t'(work_head_bits);
    assign result_head = ctu_pkg::result_t'(result_head_bits);

    ctu_front #(
        .POLY_COUNT (POLY_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cipher_byte (cipher_byte),
        .work_valid  (work_valid),
        .work        (work_in)
    );

    ctu_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (ctu_pkg::WORK_DEPTH)
    ) u_work_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_valid),
        .wdata (work_in),
        .full  (full),
        .pop   (work_pop),
        .rdata (work_head_bits),
        .empty (work_empty)
    );

    ctu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work        (work_head),
        .work_empty  (work_empty),
        .work_pop    (work_pop),
        .result_full (result_full),
        .result_push (result_push),
        .result      (result_in)
    );

    ctu_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (ctu_pkg::RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (result_in),
        .full  (result_full),
        .pop   (pop),
        .rdata (result_head_bits),
        .empty (empty)
    );

    assign coefficient = result_head.coefficient;
    assign poly_select = result_head.poly_select;
    assign coeff_index = result_head.coeff_index;
    assign run_last    = result_head.run_last;
    assign cipher_last = result_head.cipher_last;

endmodule

`default_nettype wire

FILE: test/tb_mlkem_ciphertext_unpack.sv
// Testbench for the ML-KEM ciphertext unpacker: byte stream in, decompressed coefficients out.

class coeff_scoreboard;
    int unsigned      c1_bytes;
    int unsigned      cipher_bytes;
    logic [10:0]      byte_pos;
    logic [16:0]      gear;
    logic [4:0]       gear_fill;
    logic [9:0]       coeff_cnt;
    ctu_pkg::result_t coeff_q[$];
    int unsigned      mismatches;

    function new(int unsigned u_polys);
        c1_bytes     = u_polys * ctu_pkg::C1_POLY_BYTES;
        cipher_bytes = c1_bytes + ctu_pkg::C2_BYTES;
        mismatches   = 0;
        clear_state();
    endfunction

    function void clear_state();
        byte_pos  = '0;
        gear      = '0;
        gear_fill = '0;
        coeff_cnt = '0;
    endfunction

    function logic [11:0] grow10(logic [9:0] x);
        int unsigned t;
        t = x * 3329 + 512;
        return 12'(t >> 10);
    endfunction

    function logic [11:0] grow4(logic [3:0] x);
        int unsigned t;
        t = x * 3329 + 8;
        return 12'(t >> 4);
    endfunction

    function int unsigned pending();
        return coeff_q.size();
    endfunction

    // Predict the coefficients that one accepted byte releases.
    function void note_byte(logic [7:0] b);
        bit               closing;
        ctu_pkg::result_t r;
        closing = (int'(byte_pos) + 1 >= cipher_bytes);
        if (byte_pos < c1_bytes)
        begin
            gear      = gear | (17'(b) << gear_fill[3:0]);
            gear_fill = gear_fill + 5'd8;
            if (gear_fill >= 5'd10)
            begin
                r.coefficient = grow10(gear[9:0]);
                r.poly_select = coeff_cnt[9:8];
                r.coeff_index = coeff_cnt[7:0];
                r.run_last    = 1'b1;
                r.cipher_last = 1'b0;
                coeff_q.push_back(r);
                gear      = gear >> 10;
                gear_fill = gear_fill - 5'd10;
                coeff_cnt = coeff_cnt + 10'd1;
            end
        end
        else
        begin
            // low nibble first, run_last only on the high one
            r.coefficient = grow4(b[3:0]);
            r.poly_select = ctu_pkg::V_POLY_SELECT;
            r.coeff_index = coeff_cnt[7:0];
            r.run_last    = 1'b0;
            r.cipher_last = 1'b0;
            coeff_q.push_back(r);
            coeff_cnt     = coeff_cnt + 10'd1;
            r.coefficient = grow4(b[7:4]);
            r.coeff_index = coeff_cnt[7:0];
            r.run_last    = 1'b1;
            r.cipher_last = closing;
            coeff_q.push_back(r);
            coeff_cnt     = coeff_cnt + 10'd1;
        end
        byte_pos = byte_pos + 11'd1;
        if (closing)
            clear_state();
    endfunction

    function void check_result(ctu_pkg::result_t got);
        ctu_pkg::result_t want;
        if (coeff_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected coefficient %0d poly %0d idx %0d rl %0b cl %0b",
                         $realtime, got.coefficient, got.poly_select, got.coeff_index,
                         got.run_last, got.cipher_last);
            return;
        end
        want = coeff_q.pop_front();
        if (got.coefficient !== want.coefficient || got.poly_select !== want.poly_select
            || got.coeff_index !== want.coeff_index || got.run_last !== want.run_last
            || got.cipher_last !== want.cipher_last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp coef %0d poly %0d idx %0d rl %0b cl %0b,",
                         $realtime, want.coefficient, want.poly_select, want.coeff_index,
                         want.run_last, want.cipher_last,
                         " got coef %0d poly %0d idx %0d rl %0b cl %0b",
                         got.coefficient, got.poly_select, got.coeff_index,
                         got.run_last, got.cipher_last);
        end
    endfunction
endclass

module tb_mlkem_ciphertext_unpack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int U_POLYS      = ctu_pkg::POLY_COUNT_DEFAULT;
    localparam int STREAM_BYTES = 400;
    localparam int CALM_BYTES   = 80;
    localparam int DRAIN_AT     = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [7:0] OPENING [20] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic [7:0]  cipher_byte = 8'h00;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [11:0] coefficient;
    logic [1:0]  poly_select;
    logic [7:0]  coeff_index;
    logic        run_last;
    logic        cipher_last;

    coeff_scoreboard sb = new(U_POLYS);
    bit              calm = 1'b0;
    int unsigned     stall_cycles = 0;

    mlkem_ciphertext_unpack #(
        .POLY_COUNT (U_POLYS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cipher_byte (cipher_byte),
        .empty       (empty),
        .pop         (pop),
        .coefficient (coefficient),
        .poly_select (poly_select),
        .coeff_index (coeff_index),
        .run_last    (run_last),
        .cipher_last (cipher_last)
    );

    always #10 clk = ~clk;

    // Leave push high on return so back-to-back beats need no second assignment.
    task automatic send_byte(input logic [7:0] b);
        push        <= 1'b1;
        cipher_byte <= b;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(0, 1) ? 8'h0F : 8'hF0;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        int unsigned sent;
        bit          quiet;
        quiet = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (OPENING[i])
            send_byte(OPENING[i]);
        for (sent = $size(OPENING); sent < STREAM_BYTES; sent++)
        begin
            if (sent % 128 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (sent >= STREAM_BYTES - CALM_BYTES)
                calm = 1'b1;
            if (sent == DRAIN_AT)
            begin
                // hold the stream until every coefficient so far has been read
                push <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            else if (!calm && !quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
            send_byte(pick_byte());
        end
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned      results_seen;
        int unsigned      hold_left;
        int unsigned      idle_left;
        ctu_pkg::result_t got;
        results_seen = 0;
        hold_left    = 0;
        idle_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got = '{coefficient, poly_select, coeff_index, run_last, cipher_last};
                sb.check_result(got);
                results_seen++;
                // starve the output long enough for the block to fill and stall input
                if (results_seen == 100 || results_seen == 200)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                idle_left = $urandom_range(1, 9) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
